FILE: design/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types and constants for the fractional delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

  // Sample width, Q1.23
  localparam int SAMPLE_BITS = 24;
  // Delay fraction width
  localparam int FRAC_BITS = 16;
  // Op field width of a queue word
  localparam int OP_BITS = 2;

  // Operation codes
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_CUBIC  = 2'd1,
    OP_LINEAR = 2'd2,
    OP_WHOLE  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic REG_DELAY_LENGTH   = 1'b0;
  localparam logic REG_SAMPLES_PER_MS = 1'b1;

  // Cubic: divide by six through a reciprocal, after clamping the input
  localparam logic [27:0]        RECIP_SIX = 28'd178956971;  // ceil(2^30 / 6)
  localparam logic signed [33:0] SAT_SPAN  = 34'sd50331648;  // 6 * 2^23

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADDR
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_RD,
    B_LAST,
    B_C1,
    B_C2,
    B_C3,
    B_C4,
    B_C5,
    B_C6,
    B_C7,
    B_C8,
    B_OUT
  } back_state_t;

endpackage

FILE: design/fdl_front.sv
// ----------------------------------------------------------------------------
// fdl_front
// Accepts words, scales delays, clamps them and forms ring addresses.
// ----------------------------------------------------------------------------
module fdl_front #(
  parameter int MAX_LENGTH = 4096,
  parameter int AW = 12,
  parameter int LW = 13
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           op,
  input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [19:0]                          delay_ms,
  input  logic [15:0]                          delay_samples,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [23:0]                          cfg_data,
  input  logic                                 clearing,
  input  logic                                 q_full,
  output logic                                 q_push,
  output logic [1:0]                           q_op,
  output logic signed [fdl_pkg::SAMPLE_BITS-1:0] q_sample,
  output logic [AW-1:0]                        q_base,
  output logic [fdl_pkg::FRAC_BITS-1:0]        q_frac,
  output logic [LW-1:0]                        ring_len
);
  import fdl_pkg::*;

  localparam int LEN_RESET = (MAX_LENGTH < 4096) ? MAX_LENGTH : 4096;

  front_state_t state, state_next;
  op_t                          op_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [19:0]                  dms_q;
  logic [15:0]                  dsm_q;
  logic [43:0]                  prod;
  logic [23:0]                  spm;
  logic [LW-1:0]                len;
  logic [AW-1:0]                wpos;

  logic [LW-1:0]   len_m1, whole, cfg_len;
  logic [19:0]     ip;
  logic [FRAC_BITS-1:0] frac;
  logic [LW:0]     bsum;
  logic [AW-1:0]   base;
  logic [LW:0]     wnext;

  assign cfg_ready = 1'b1;
  assign ring_len  = len;
  assign in_stall  = (state != F_IDLE) || clearing;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid && !in_stall) state_next = F_MUL;
      F_MUL:  state_next = F_ADDR;
      F_ADDR: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Delay clamp and base address
  always_comb begin
    len_m1 = len - LW'(1);
    ip     = prod[43:24];
    frac   = '0;
    if (op_q == OP_WHOLE) begin
      if (32'(dsm_q) > 32'(len_m1)) whole = len_m1;
      else whole = LW'(dsm_q);
    end else if (32'(ip) > 32'(len_m1)) begin
      whole = len_m1;
    end else begin
      whole = LW'(ip);
      frac  = prod[23:8];
    end
    bsum = (LW+1)'(wpos) + (LW+1)'(len) - (LW+1)'(whole);
    if (bsum >= (LW+1)'(len)) bsum = bsum - (LW+1)'(len);
    base  = (op_q == OP_WRITE) ? wpos : bsum[AW-1:0];
    wnext = (LW+1)'(wpos) + (LW+1)'(1);
    // Ring length: zero acts as one, large values clamp
    if (cfg_data[12:0] == 13'd0) cfg_len = LW'(1);
    else if (32'(cfg_data[12:0]) > MAX_LENGTH) cfg_len = LW'(MAX_LENGTH);
    else cfg_len = LW'(cfg_data[12:0]);
  end

  // Queue outputs
  always_comb begin
    q_push   = (state == F_ADDR) && !q_full;
    q_op     = op_q;
    q_sample = sample_q;
    q_base   = base;
    q_frac   = frac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      len   <= LW'(LEN_RESET);
      spm   <= 24'd2890138;
      wpos  <= '0;
    end else begin
      state <= state_next;
      if (state == F_ADDR && !q_full && op_q == OP_WRITE) begin
        wpos <= (wnext >= (LW+1)'(len)) ? '0 : wnext[AW-1:0];
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELAY_LENGTH: begin
            len  <= cfg_len;
            wpos <= '0;
          end
          REG_SAMPLES_PER_MS: spm <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid && !in_stall) begin
      op_q     <= op_t'(op);
      sample_q <= sample;
      dms_q    <= delay_ms;
      dsm_q    <= delay_samples;
    end
    if (state == F_MUL) prod <= 44'(dms_q) * 44'(spm);
  end

endmodule

FILE: design/fdl_queue.sv
// ----------------------------------------------------------------------------
// fdl_queue
// Four-entry queue of commands between front and back.
// ----------------------------------------------------------------------------
module fdl_queue #(
  parameter int W = 54
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_word,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] head_word,
  output logic         empty
);
  import fdl_pkg::*;

  logic [W-1:0] slots [4];
  logic [1:0]   wr_ptr, rd_ptr;
  logic [2:0]   count;

  assign full      = (count == 3'd4);
  assign empty     = (count == 3'd0);
  assign head_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 2'd1;
      if (pop && !empty) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push && !full) - 3'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_word;
  end

endmodule

FILE: design/fdl_back.sv
// ----------------------------------------------------------------------------
// fdl_back
// Executes commands: ring memory writes, tap reads and interpolation.
// ----------------------------------------------------------------------------
module fdl_back #(
  parameter int MAX_LENGTH = 4096,
  parameter int AW = 12,
  parameter int LW = 13
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [LW-1:0]                        ring_len,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic [1:0]                           h_op,
  input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] h_sample,
  input  logic [AW-1:0]                        h_base,
  input  logic [fdl_pkg::FRAC_BITS-1:0]        h_frac,
  output logic                                 clearing,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fdl_pkg::SAMPLE_BITS-1:0] value
);
  import fdl_pkg::*;

  back_state_t state, state_next;

  // Ring memory
  logic signed [SAMPLE_BITS-1:0] mem [MAX_LENGTH];
  logic                          mem_we;
  logic [AW-1:0]                 mem_addr;
  logic signed [SAMPLE_BITS-1:0] mem_wdata, rd_data;

  logic [AW-1:0]   clr_cnt;
  op_t             cur_op;
  logic [AW-1:0]   cur_base;
  logic [FRAC_BITS-1:0] cur_frac;
  logic [1:0]      rd_cnt, rd_k, last_k;
  logic            rd_pend;
  logic signed [SAMPLE_BITS-1:0] taps [4];
  logic signed [LW+1:0] tsum;
  logic [AW-1:0]   tap_addr;

  // Arithmetic
  logic signed [17:0] fs, omf;
  logic signed [24:0] cb;
  logic signed [27:0] t1, t2;
  logic signed [41:0] p1, p0;
  logic signed [42:0] lsum;
  logic signed [26:0] lr;
  logic signed [45:0] inner;
  logic signed [63:0] qprod, cb6, xdiff;
  logic signed [47:0] x16;
  logic signed [65:0] fx, b6, csum;
  logic signed [33:0] nq, mw;
  logic [26:0]     m;
  logic [54:0]     mq;
  logic [23:0]     qv;
  logic            sat_hi, sat_lo;
  logic signed [SAMPLE_BITS-1:0] res;
  logic            out_load;

  assign clearing = (state == B_CLEAR);
  assign out_load = (state == B_OUT) && (!out_valid || !out_stall);

  always_comb begin
    case (cur_op)
      OP_CUBIC:  last_k = 2'd3;
      OP_LINEAR: last_k = 2'd1;
      default:   last_k = 2'd0;
    endcase
    // Tap k sits k entries before the base, wrapping at the ring length;
    // rings shorter than the tap span wrap more than once
    tsum = $signed((LW+2)'(cur_base)) - $signed((LW+2)'(rd_cnt));
    if (tsum < 0) tsum = tsum + $signed((LW+2)'(ring_len));
    if (tsum < 0) tsum = tsum + $signed((LW+2)'(ring_len));
    if (tsum < 0) tsum = tsum + $signed((LW+2)'(ring_len));
    tap_addr = tsum[AW-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr_cnt == AW'(MAX_LENGTH - 1)) state_next = B_IDLE;
      B_IDLE:  if (!q_empty && op_t'(h_op) != OP_WRITE) state_next = B_RD;
      B_RD:    if (rd_cnt == last_k) state_next = B_LAST;
      B_LAST:  state_next = B_C1;
      B_C1:    state_next = (cur_op == OP_WHOLE) ? B_OUT : B_C2;
      B_C2:    state_next = (cur_op == OP_LINEAR) ? B_OUT : B_C3;
      B_C3:    state_next = B_C4;
      B_C4:    state_next = B_C5;
      B_C5:    state_next = B_C6;
      B_C6:    state_next = B_C7;
      B_C7:    state_next = B_C8;
      B_C8:    state_next = B_OUT;
      B_OUT:   if (!out_valid || !out_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Memory and queue control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = tap_addr;
    mem_wdata = '0;
    q_pop     = 1'b0;
    case (state)
      B_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      B_IDLE: begin
        q_pop = !q_empty;
        if (op_t'(h_op) == OP_WRITE) begin
          mem_we    = !q_empty;
          mem_addr  = h_base;
          mem_wdata = h_sample;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // Combinational arithmetic for each step
  always_comb begin
    fs    = $signed({2'b00, cur_frac});
    omf   = $signed(18'h10000 - {2'b00, cur_frac});
    lsum  = 43'(p1) + 43'(p0) + 43'sd32768;
    lr    = lsum[42:16];
    cb6   = (64'(cb) <<< 2) + (64'(cb) <<< 1);
    xdiff = (cb6 <<< 32) - qprod;
    b6    = (66'(taps[1]) <<< 2) + (66'(taps[1]) <<< 1);
    csum  = (b6 <<< 32) + fx + (66'sd3 <<< 32);
    nq    = csum[65:32];
    mw    = nq + SAT_SPAN;
    qv    = mq[53:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_cnt   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == B_RD);
      if (state == B_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_k <= rd_cnt;
    if (rd_pend) taps[rd_k] <= rd_data;
    if (out_load) value <= res;
    case (state)
      B_IDLE: begin
        cur_op   <= op_t'(h_op);
        cur_base <= h_base;
        cur_frac <= h_frac;
        rd_cnt   <= '0;
      end
      B_RD: if (rd_cnt != last_k) rd_cnt <= rd_cnt + 2'd1;
      B_C1: begin
        res <= taps[0];
        cb  <= 25'(taps[2]) - 25'(taps[1]);
        t1  <= 28'(taps[3]) - 28'(taps[0])
               - ((28'(taps[2]) - 28'(taps[1])) <<< 1) - (28'(taps[2]) - 28'(taps[1]));
        t2  <= 28'(taps[3]) + (28'(taps[0]) <<< 1) - (28'(taps[1]) <<< 1) - 28'(taps[1]);
        p1  <= 42'(taps[1]) * 42'(fs);
        p0  <= 42'(taps[0]) * 42'(omf);
      end
      B_C2: begin
        inner <= 46'(t1) * 46'(fs) + (46'(t2) <<< 16);
        if (lr > 27'sd8388607) res <= 24'sh7FFFFF;
        else if (lr < -27'sd8388608) res <= 24'sh800000;
        else res <= lr[23:0];
      end
      B_C3: qprod <= 64'(inner) * 64'(omf);
      B_C4: x16 <= xdiff[63:16];
      B_C5: fx <= 66'(x16) * 66'(fs);
      B_C6: begin
        sat_hi <= (nq >= SAT_SPAN);
        sat_lo <= (nq < -SAT_SPAN);
        m      <= mw[26:0];
      end
      B_C7: mq <= 55'(m) * 55'(RECIP_SIX);
      B_C8: begin
        if (sat_hi) res <= 24'sh7FFFFF;
        else if (sat_lo) res <= 24'sh800000;
        else res <= $signed({~qv[23], qv[22:0]});
      end
      default: ;
    endcase
  end

endmodule

FILE: design/fractional_delay_line.sv
// Flow: the front takes a word, scales its delay and pushes it to the queue; the
// back writes a sample straight from the queue, or reads the taps (one ring read a
// cycle on the single-port memory), then runs the interpolation steps.
// The front takes no new word until it has pushed the last one; the back bounds
// the rate per op. Reset: a clearing pass zeroes the ring; no word is taken
// then. Config registers go to their defaults.
// ----------------------------------------------------------------------------
// fractional_delay_line
// Audio delay ring with whole, linear and cubic fractional reads.
// ----------------------------------------------------------------------------
module fractional_delay_line #(
  parameter int MAX_LENGTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             op,
  input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [19:0]                            delay_ms,
  input  logic [15:0]                            delay_samples,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [fdl_pkg::SAMPLE_BITS-1:0] value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [23:0]                            cfg_data
);
  import fdl_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int W  = OP_BITS + SAMPLE_BITS + AW + FRAC_BITS;

  logic                   clearing, q_full, q_push, q_pop, q_empty;
  logic [1:0]             f_op;
  logic signed [SAMPLE_BITS-1:0] f_sample;
  logic [AW-1:0]          f_base;
  logic [FRAC_BITS-1:0]   f_frac;
  logic [LW-1:0]          ring_len;
  logic [W-1:0]           head;

  fdl_front #(.MAX_LENGTH(MAX_LENGTH), .AW(AW), .LW(LW)) u_front (
    .clk, .rst, .in_valid, .in_stall, .op, .sample, .delay_ms, .delay_samples,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .clearing, .q_full, .q_push,
    .q_op(f_op), .q_sample(f_sample), .q_base(f_base), .q_frac(f_frac), .ring_len
  );

  fdl_queue #(.W(W)) u_queue (
    .clk, .rst, .push(q_push), .push_word({f_op, f_sample, f_base, f_frac}),
    .full(q_full), .pop(q_pop), .head_word(head), .empty(q_empty)
  );

  fdl_back #(.MAX_LENGTH(MAX_LENGTH), .AW(AW), .LW(LW)) u_back (
    .clk, .rst, .ring_len, .q_empty, .q_pop,
    .h_op(head[W-1 -: OP_BITS]),
    .h_sample($signed(head[W-OP_BITS-1 -: SAMPLE_BITS])),
    .h_base(head[FRAC_BITS +: AW]),
    .h_frac(head[FRAC_BITS-1:0]),
    .clearing, .out_valid, .out_stall, .value
  );

endmodule

FILE: verif/tb_fractional_delay_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractional_delay_line
// Drives writes and whole, linear and cubic reads through the delay ring under
// random sender gaps and receiver stalls, over several ring length and rate
// settings, and checks every returned value against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_fractional_delay_line;
  import fdl_pkg::*;

  localparam int RING_MAX = 4096;

  // Ring predictor and expected value store
  class delay_scoreboard;
    logic signed [SAMPLE_BITS-1:0] ring [RING_MAX];
    int unsigned                   wr_pos;
    logic [12:0]                   len_reg;
    logic [23:0]                   rate_reg;
    logic [SAMPLE_BITS-1:0]        expected_values [$];
    int                            mismatches;
    int                            checked;
    int                            op_count [4];

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos   = 0;
      len_reg  = 13'd4096;
      rate_reg = 24'd2890138;
      mismatches = 0;
      checked    = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
    endfunction

    function int unsigned ring_len();
      if (len_reg == 0) return 1;
      if (len_reg > RING_MAX) return RING_MAX;
      return len_reg;
    endfunction

    function longint tap(int unsigned base, int unsigned k, int unsigned len);
      return longint'(ring[(base + 4 * len - k) % len]);
    endfunction

    function void set_register(logic idx, logic [23:0] data);
      if (idx == REG_DELAY_LENGTH) begin
        len_reg = data[12:0];
        wr_pos  = 0;
      end else begin
        rate_reg = data;
      end
    endfunction

    function void note_input(op_t op, logic signed [SAMPLE_BITS-1:0] smp,
                             logic [19:0] dms, logic [15:0] dsmp);
      int unsigned len, p, whole, frac, base;
      longint unsigned prod;
      longint a, b, c, d, f, cb, t1, t2, inner, q, x, x16, sum, res;
      len = ring_len();
      p = wr_pos % len;
      frac = 0;
      op_count[op]++;
      if (op == OP_WRITE) begin
        ring[p] = smp;
        p++;
        if (p >= len) p = 0;
        wr_pos = p;
        return;
      end
      if (op == OP_WHOLE) begin
        whole = (dsmp > len - 1) ? len - 1 : dsmp;
      end else begin
        prod = longint'(dms) * longint'(rate_reg);
        if ((prod >> 24) > len - 1) begin
          whole = len - 1;
        end else begin
          whole = int'(prod >> 24);
          frac  = int'((prod >> 8) & 64'hFFFF);
        end
      end
      base = (p + len - whole) % len;
      a = tap(base, 0, len);
      b = tap(base, 1, len);
      if (op == OP_WHOLE) begin
        res = a;
      end else if (op == OP_LINEAR) begin
        res = fdiv(b * frac + a * (65536 - frac) + 32768, 65536);
      end else begin
        c = tap(base, 2, len);
        d = tap(base, 3, len);
        f = frac;
        cb = c - b;
        t1 = d - a - 3 * cb;
        t2 = d + 2 * a - 3 * b;
        inner = t1 * f + t2 * 65536;
        q = inner * (65536 - f);
        x = cb * 6 * (64'sd1 << 32) - q;
        x16 = fdiv(x, 65536);
        sum = b * 6 * (64'sd1 << 32) + f * x16;
        res = fdiv(sum + 3 * (64'sd1 << 32), 6 * (64'sd1 << 32));
      end
      // saturate to the sample range
      if (res > 8388607) res = 8388607;
      if (res < -8388608) res = -8388608;
      expected_values.push_back(res[SAMPLE_BITS-1:0]);
    endfunction

    function void check_value(logic [SAMPLE_BITS-1:0] got);
      logic [SAMPLE_BITS-1:0] want;
      checked++;
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected value %h", got);
        return;
      end
      want = expected_values.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: value mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    op;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [19:0]                   delay_ms;
  logic [15:0]                   delay_samples;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic                          cfg_index;
  logic [23:0]                   cfg_data;

  delay_scoreboard sb = new();
  int hold_req;
  int hold_left;
  int stall_mode;
  int mode_cycles;

  fractional_delay_line dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .sample(sample), .delay_ms(delay_ms), .delay_samples(delay_samples),
    .out_valid(out_valid), .out_stall(out_stall), .value(value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stall patterns in turn, plus requested long holds
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      mode_cycles = 0;
      stall_mode = 0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_cycles = 32;
      end
      mode_cycles--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (mode_cycles >= 16);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_value(value);
  end

  // Offer one word and wait for it to be taken
  task automatic send_word(op_t o, logic [23:0] s, logic [19:0] dms, logic [15:0] dsmp);
    in_valid      <= 1'b1;
    op            <= o;
    sample        <= s;
    delay_ms      <= dms;
    delay_samples <= dsmp;
    do @(posedge clk); while (in_stall);
    sb.note_input(o, s, dms, dsmp);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Quiet the block fully, then write one register
  task automatic write_register(logic idx, logic [23:0] data);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.expected_values.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Random word: delays mostly within the ring, some anywhere in the field
  task automatic send_random(int unsigned len);
    op_t         o;
    logic [19:0] dms;
    logic [15:0] dsmp;
    o = op_t'($urandom_range(0, 9) < 4 ? OP_WRITE : $urandom_range(1, 3));
    if ($urandom_range(0, 3) == 0) begin
      dms  = 20'($urandom);
      dsmp = 16'($urandom);
    end else begin
      dms  = 20'($urandom_range(0, (len < 4096 ? len : 4096) * 4 + 7));
      dsmp = 16'($urandom_range(0, len + 2));
    end
    send_word(o, 24'($urandom), dms, dsmp);
  endtask

  // Random burst traffic with gaps
  task automatic run_traffic(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        send_random(sb.ring_len());
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
    end
  endtask

  // Fill the output side: long receiver hold while words keep coming
  task automatic squeeze_output();
    hold_req = 400;
    repeat (40) send_word(OP_LINEAR, '0, 20'($urandom_range(0, 2000)), '0);
  endtask

  initial begin
    int guard;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    op            <= OP_WRITE;
    sample        <= '0;
    delay_ms      <= '0;
    delay_samples <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_DELAY_LENGTH;
    cfg_data      <= '0;
    hold_req = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme samples, each op, clamped and fractional delays
    send_word(OP_WRITE, 24'h7FFFFF, '0, '0);
    send_word(OP_WRITE, 24'h800000, '0, '0);
    send_word(OP_WRITE, 24'h7FFFFF, '0, '0);
    send_word(OP_WRITE, 24'h800000, '0, '0);
    send_word(OP_WRITE, 24'h000001, '0, '0);
    send_word(OP_WRITE, 24'hFFFFFF, '0, '0);
    send_word(OP_WHOLE, '0, '0, 16'd0);
    send_word(OP_WHOLE, '0, '0, 16'd1);
    send_word(OP_WHOLE, '0, '0, 16'hFFFF);
    send_word(OP_LINEAR, '0, 20'd0, '0);
    send_word(OP_LINEAR, '0, 20'd13, '0);
    send_word(OP_LINEAR, '0, 20'hFFFFF, '0);
    send_word(OP_CUBIC, '0, 20'd0, '0);
    send_word(OP_CUBIC, '0, 20'd7, '0);
    send_word(OP_CUBIC, '0, 20'd17, '0);
    send_word(OP_CUBIC, '0, 20'd23, '0);
    send_word(OP_CUBIC, '0, 20'hFFFFF, '0);
    send_word(OP_LINEAR, '0, 20'd29, '0);
    idle_cycles(1);

    // Settings: default, extremes, out-of-range lengths, assorted
    run_traffic(200);
    squeeze_output();
    write_register(REG_DELAY_LENGTH, 24'd1);
    write_register(REG_SAMPLES_PER_MS, 24'd0);
    run_traffic(120);
    write_register(REG_DELAY_LENGTH, 24'd4096);
    write_register(REG_SAMPLES_PER_MS, 24'hFFFFFF);
    run_traffic(200);
    write_register(REG_DELAY_LENGTH, 24'd0);
    run_traffic(80);
    write_register(REG_DELAY_LENGTH, 24'hFFFFFF);
    write_register(REG_SAMPLES_PER_MS, 24'($urandom_range(1, 24'hFFFFFF)));
    run_traffic(150);
    write_register(REG_DELAY_LENGTH, 24'd5);
    write_register(REG_SAMPLES_PER_MS, 24'd65536);
    run_traffic(200);
    // sender pause until every expected value has come
    in_valid <= 1'b0;
    guard = 0;
    while (sb.expected_values.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    write_register(REG_DELAY_LENGTH, 24'd37);
    write_register(REG_SAMPLES_PER_MS, 24'($urandom_range(1000, 400000)));
    run_traffic(200);
    squeeze_output();
    write_register(REG_DELAY_LENGTH, 24'($urandom_range(64, 700)));
    write_register(REG_SAMPLES_PER_MS, 24'($urandom));
    run_traffic(200);
    write_register(REG_DELAY_LENGTH, 24'd2);
    write_register(REG_SAMPLES_PER_MS, 24'd2890138);
    run_traffic(200);
    in_valid <= 1'b0;

    // Drain
    guard = 0;
    while (sb.expected_values.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (sb.expected_values.size() != 0) begin
      $display("ERROR: %0d expected values never arrived", sb.expected_values.size());
      sb.mismatches++;
    end
    $display("Ran %0d writes, %0d cubic, %0d linear, %0d whole reads over 9 settings;",
             sb.op_count[OP_WRITE], sb.op_count[OP_CUBIC], sb.op_count[OP_LINEAR],
             sb.op_count[OP_WHOLE]);
    $display("%0d values checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8ms;
    $display("ERROR: timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
